// ===== hdl/lpwf_pkg.sv =====
`timescale 1ns / 1ps
package lpwf_pkg;
	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 24;
	localparam int LA_BITS = 17;
	localparam int IDX_OUT_BITS = 10;
	localparam logic [LA_BITS-1:0] LA_RESET = 17'd3000;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_N_RD,
		ST_N_DIFF,
		ST_N_SQ,
		ST_N_CMP,
		ST_W_RD0,
		ST_W_RD1,
		ST_W_DIFF,
		ST_W_SQ,
		ST_W_SUMSQ,
		ST_W_SQRT,
		ST_W_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} sqrt_ctl_t;
endpackage

// ===== hdl/lpwf_sqrt.sv =====
`timescale 1ns / 1ps
module lpwf_sqrt import lpwf_pkg::*; #(
	parameter int IN_BITS = 50
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [IN_BITS-1:0]   radicand,
	output sqrt_ctl_t            ctl,
	output logic [IN_BITS/2:0]   root
);
	localparam int RB = IN_BITS / 2 + 1;
	localparam int NB = 2 * RB;
	localparam int CB = $clog2(RB + 1);

	logic [NB-1:0] rem_q;
	logic [NB-1:0] num_q;
	logic [RB-1:0] res_q;
	logic [CB-1:0] cnt_q;
	logic          busy_q;
	logic [NB-1:0] trial;
	logic [NB-1:0] rem_sh;

	assign rem_sh = {rem_q[NB-3:0], num_q[NB-1:NB-2]};
	assign trial  = {{(NB-RB-2){1'b0}}, res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CB'(RB);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CB'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= NB'(radicand);
			res_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 2;
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				res_q <= {res_q[RB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				res_q <= {res_q[RB-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign root      = res_q;
endmodule

// ===== hdl/local_path_window_finder.sv =====
`timescale 1ns / 1ps
// local path window finder
// input channel (in_valid/in_ready): action, pos_x, pos_y. clear and append
// items give no result and leave the block idle. a query on a non-empty path
// gives one result item on the output channel (out_valid/out_ready) with
// start_index, end_index, length_reached and overflowed.
// a query first scans all n stored points for the nearest one, each point
// through the read, difference, square and compare states, then walks
// forward segment by segment, taking the length of each segment from the
// bit-serial square root unit, until the look-ahead length is met or the
// path ends.
// in_ready is low while a query runs and while a result waits; a stalled
// receiver holds the block in the output state with the result unchanged.
// lookahead_length is written by cfg_we/cfg_wdata at any edge.
// reset clears the point count, the overflow flag, the look-ahead length
// to 3000 and the sequencer; the waypoint store needs no clearing.
module local_path_window_finder import lpwf_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [IDX_OUT_BITS-1:0]      start_index,
	output logic [IDX_OUT_BITS-1:0]      end_index,
	output logic                         length_reached,
	output logic                         overflowed,
	input  logic                         cfg_we,
	input  logic [LA_BITS-1:0]           cfg_wdata
);
	localparam int AB = $clog2(MAX_POINTS);
	localparam int CNTB = $clog2(MAX_POINTS + 1);
	localparam int DB = COORD_BITS + 1;
	localparam int SQB = 2 * DB;
	localparam int DSB = SQB + 1;
	localparam int RTB = DSB / 2 + 1;
	localparam int SUMB = RTB + CNTB + 1;

	logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
	logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
	logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;
	logic [AB-1:0]   rd_addr;
	logic            rd_en;

	state_t state_q, state_d;
	logic [CNTB-1:0] count_q;
	logic            ovf_q;
	logic [LA_BITS-1:0] la_q;
	logic signed [COORD_BITS-1:0] vx_q, vy_q, px_q, py_q;
	logic [CNTB-1:0] idx_q;
	logic [AB-1:0]   best_q;
	logic [DSB-1:0]  best_d_q;
	logic [DSB-1:0]  sq_sum;
	logic [DB-1:0]   ax_q, ay_q;
	logic [SQB-1:0]  sqx_q, sqy_q;
	logic [SUMB-1:0] sum_q;
	logic [AB-1:0]   end_q;
	logic            reached_q;
	logic            sq_start;
	sqrt_ctl_t       sq_ctl;
	logic [RTB-1:0]  sq_root;
	logic [SUMB-1:0] sum_next;
	logic signed [DB-1:0] dx, dy;
	logic            accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept && action == ACT_APPEND && count_q < CNTB'(MAX_POINTS)) begin
			mem_x[count_q[AB-1:0]] <= pos_x;
			mem_y[count_q[AB-1:0]] <= pos_y;
		end
		if (rd_en) begin
			rd_x_q <= mem_x[rd_addr];
			rd_y_q <= mem_y[rd_addr];
		end
	end

	always_comb begin
		dx = state_q == ST_N_DIFF ? DB'(rd_x_q) - DB'(vx_q) : DB'(rd_x_q) - DB'(px_q);
		dy = state_q == ST_N_DIFF ? DB'(rd_y_q) - DB'(vy_q) : DB'(rd_y_q) - DB'(py_q);
	end

	assign sq_sum   = DSB'(sqx_q) + DSB'(sqy_q);
	assign sum_next = sum_q + SUMB'(sq_root);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = idx_q[AB-1:0];
		sq_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept && action == ACT_QUERY && count_q != '0) state_d = ST_N_RD;
			end
			ST_N_RD: begin
				rd_en   = 1'b1;
				state_d = ST_N_DIFF;
			end
			ST_N_DIFF: state_d = ST_N_SQ;
			ST_N_SQ:   state_d = ST_N_CMP;
			ST_N_CMP: begin
				if (idx_q + 1'b1 == count_q) state_d = ST_W_RD0;
				else state_d = ST_N_RD;
			end
			ST_W_RD0: begin
				if (CNTB'(best_q) + 1'b1 >= count_q) state_d = ST_OUT;
				else begin
					rd_en   = 1'b1;
					rd_addr = best_q;
					state_d = ST_W_RD1;
				end
			end
			ST_W_RD1: begin
				rd_en   = 1'b1;
				state_d = ST_W_DIFF;
			end
			ST_W_DIFF:  state_d = ST_W_SQ;
			ST_W_SQ:    state_d = ST_W_SUMSQ;
			ST_W_SUMSQ: begin
				sq_start = 1'b1;
				state_d  = ST_W_SQRT;
			end
			ST_W_SQRT: if (!sq_ctl.busy) state_d = ST_W_ACC;
			ST_W_ACC: begin
				if (sum_next >= SUMB'(la_q) || idx_q + 1'b1 >= count_q) state_d = ST_OUT;
				else begin
					rd_en   = 1'b1;
					rd_addr = AB'(idx_q + 1'b1);
					state_d = ST_W_DIFF;
				end
			end
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			la_q    <= LA_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) la_q <= cfg_wdata;
			if (accept && action == ACT_CLEAR) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (accept && action == ACT_APPEND) begin
				if (count_q < CNTB'(MAX_POINTS)) count_q <= count_q + 1'b1;
				else ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				vx_q  <= pos_x;
				vy_q  <= pos_y;
				idx_q <= '0;
			end
			ST_N_DIFF, ST_W_DIFF: begin
				ax_q <= dx[DB-1] ? DB'(-dx) : DB'(dx);
				ay_q <= dy[DB-1] ? DB'(-dy) : DB'(dy);
			end
			ST_N_SQ, ST_W_SQ: begin
				sqx_q <= ax_q * ax_q;
				sqy_q <= ay_q * ay_q;
			end
			ST_N_CMP: begin
				if (idx_q == '0 || sq_sum < best_d_q) begin
					best_d_q <= sq_sum;
					best_q   <= idx_q[AB-1:0];
				end
				idx_q <= idx_q + 1'b1;
			end
			ST_W_RD0: begin
				idx_q     <= CNTB'(best_q) + 1'b1;
				sum_q     <= '0;
				end_q     <= AB'(count_q - 1'b1);
				reached_q <= 1'b0;
			end
			ST_W_RD1, ST_W_ACC: begin
				px_q <= rd_x_q;
				py_q <= rd_y_q;
			end
			default: ;
		endcase
		if (state_q == ST_W_ACC) begin
			sum_q <= sum_next;
			idx_q <= idx_q + 1'b1;
			if (sum_next >= SUMB'(la_q)) begin
				end_q     <= idx_q[AB-1:0];
				reached_q <= 1'b1;
			end
		end
	end

	lpwf_sqrt #(.IN_BITS(DSB)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_sum),
		.ctl      (sq_ctl),
		.root     (sq_root)
	);

	assign out_valid      = state_q == ST_OUT;
	assign start_index    = IDX_OUT_BITS'(best_q);
	assign end_index      = IDX_OUT_BITS'(end_q);
	assign length_reached = reached_q;
	assign overflowed     = ovf_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(end_index))
		else $error("result dropped");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTB'(MAX_POINTS)) else $error("count overflow");
	a_sqrt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sq_ctl.busy |-> state_q == ST_W_SQRT) else $error("sqrt busy out of step");
	a_sqrt_start: assert property (@(posedge clk) disable iff (!arst_n)
		sq_ctl.start |-> !sq_ctl.busy) else $error("sqrt started while busy");
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb import lpwf_pkg::*; ();

	typedef struct {
		logic [9:0] start_idx;
		logic [9:0] end_idx;
		logic reached;
		logic ovf;
	} window_t;

	class window_scoreboard;
		logic signed [23:0] wx[1024];
		logic signed [23:0] wy[1024];
		int unsigned count;
		bit ovf_flag;
		logic [16:0] lookahead;
		window_t pending[$];
		int errors;

		function new();
			count = 0;
			ovf_flag = 0;
			lookahead = LA_RESET;
			errors = 0;
		endfunction

		function void add_window(window_t w);
			pending.insert(pending.size(), w);
		endfunction

		function longint unsigned dsq(longint ax, longint ay, longint bx, longint by);
			longint dx;
			longint dy;
			dx = ax - bx;
			dy = ay - by;
			return dx * dx + dy * dy;
		endfunction

		function longint unsigned isqrt(longint unsigned n);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function void note_item(action_t act, logic signed [23:0] x, logic signed [23:0] y);
			int unsigned best;
			int unsigned last;
			longint unsigned bd;
			longint unsigned d;
			longint unsigned sum;
			window_t w;
			case (act)
				ACT_CLEAR: begin
					count = 0;
					ovf_flag = 0;
				end
				ACT_APPEND: begin
					if (count < 1024) begin
						wx[count] = x;
						wy[count] = y;
						count++;
					end else begin
						ovf_flag = 1;
					end
				end
				ACT_QUERY: begin
					if (count != 0) begin
						best = 0;
						bd = dsq(wx[0], wy[0], x, y);
						for (int unsigned i = 1; i < count; i++) begin
							d = dsq(wx[i], wy[i], x, y);
							if (d < bd) begin
								bd = d;
								best = i;
							end
						end
						sum = 0;
						last = count - 1;
						w.reached = 0;
						for (int unsigned i = best; i + 1 < count; i++) begin
							sum += isqrt(dsq(wx[i+1], wy[i+1], wx[i], wy[i]));
							if (sum >= lookahead) begin
								last = i + 1;
								w.reached = 1;
								break;
							end
						end
						w.start_idx = best[9:0];
						w.end_idx = last[9:0];
						w.ovf = ovf_flag;
						add_window(w);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_window(window_t got);
			window_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result start %0d end %0d", $time,
					got.start_idx, got.end_idx);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.start_idx !== e.start_idx) begin
				$display("%0t: start_index expected %0d actual %0d", $time, e.start_idx,
					got.start_idx);
				errors++;
			end
			if (got.end_idx !== e.end_idx) begin
				$display("%0t: end_index expected %0d actual %0d", $time, e.end_idx,
					got.end_idx);
				errors++;
			end
			if (got.reached !== e.reached) begin
				$display("%0t: length_reached expected %0d actual %0d", $time, e.reached,
					got.reached);
				errors++;
			end
			if (got.ovf !== e.ovf) begin
				$display("%0t: overflowed expected %0d actual %0d", $time, e.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic out_valid;
	logic out_ready;
	logic [9:0] start_index;
	logic [9:0] end_index;
	logic length_reached;
	logic overflowed;
	logic cfg_we;
	logic [16:0] cfg_wdata;

	window_scoreboard sb;
	bit sink_on;
	int stall_left;

	local_path_window_finder DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.start_index(start_index), .end_index(end_index),
		.length_reached(length_reached), .overflowed(overflowed),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(action_t act, logic signed [23:0] x, logic signed [23:0] y);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		pos_x <= x;
		pos_y <= y;
		do @(posedge clk); while (!in_ready);
		sb.note_item(act, x, y);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_lookahead(logic [16:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.lookahead = v;
	endtask

	function logic signed [23:0] rnd_near(logic signed [23:0] c, int span);
		int off;
		off = int'($urandom_range(0, 2 * span)) - span;
		return c + 24'(off);
	endfunction

	// receiver: random stalls once sink_on is set
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			window_t w;
			w.start_idx = start_index;
			w.end_idx = end_index;
			w.reached = length_reached;
			w.ovf = overflowed;
			sb.check_window(w);
		end
		if (!sink_on) begin
			out_ready <= 1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 0;
		end else begin
			stall_left <= gap_len();
			out_ready <= 1;
		end
	end

	initial begin
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		int n;
		sb = new();
		sink_on = 0;
		arst_n = 0;
		in_valid = 0;
		action = ACT_NONE;
		pos_x = 0;
		pos_y = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send_item(ACT_QUERY, 0, 0);
		send_item(ACT_APPEND, 24'sh7FFFFF, 24'sh800000);
		send_item(ACT_QUERY, 24'sh800000, 24'sh7FFFFF);
		send_item(ACT_APPEND, 24'sh800000, 24'sh7FFFFF);
		send_item(ACT_APPEND, 0, 0);
		send_item(ACT_APPEND, 0, 0);
		send_item(ACT_APPEND, 100, 0);
		send_item(ACT_QUERY, 0, 0);
		send_item(ACT_QUERY, 24'sh7FFFFF, 24'sh7FFFFF);
		send_item(ACT_NONE, 24'sh555555, 24'shAAAAAA);
		send_item(ACT_QUERY, 100, 0);
		set_lookahead(17'd0);
		send_item(ACT_QUERY, 0, 0);
		send_item(ACT_QUERY, 50, 0);
		set_lookahead(17'h1FFFF);
		send_item(ACT_QUERY, 0, 0);
		send_item(ACT_CLEAR, 0, 0);
		send_item(ACT_QUERY, 0, 0);

		// longer path
		set_lookahead(17'd3000);
		sink_on = 1;
		cx = 0;
		cy = 0;
		for (int i = 0; i < 40; i++) begin
			cx = cx + 24'($urandom_range(0, 300));
			cy = cy + 24'($urandom_range(0, 400)) - 24'sd200;
			send_item(ACT_APPEND, cx, cy);
		end
		send_item(ACT_QUERY, 0, 0);
		send_item(ACT_QUERY, cx, cy);
		send_item(ACT_CLEAR, 0, 0);

		// random phases
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_lookahead(17'd100000);
				1: set_lookahead(17'($urandom_range(0, 5000)));
				2: set_lookahead(17'd1);
				3: set_lookahead(17'($urandom_range(0, 17'h1FFFF)));
				default: set_lookahead(17'd500);
			endcase
			send_item(ACT_CLEAR, 0, 0);
			n = $urandom_range(2, 12);
			cx = 24'($urandom);
			cy = 24'($urandom);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(ACT_APPEND, 24'($urandom), 24'($urandom));
				end else begin
					cx = rnd_near(cx, 2000);
					cy = rnd_near(cy, 2000);
					send_item(ACT_APPEND, cx, cy);
				end
			end
			for (int q = 0; q < 10; q++) begin
				case ($urandom_range(0, 9))
					0: send_item(ACT_NONE, 24'($urandom), 24'($urandom));
					1: send_item(ACT_APPEND, rnd_near(cx, 3000), rnd_near(cy, 3000));
					2: send_item(ACT_QUERY, 24'($urandom), 24'($urandom));
					default: send_item(ACT_QUERY, rnd_near(cx, 20000), rnd_near(cy, 20000));
				endcase
				if (q == 5) drain();
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
